// ----- rtl/bmd_pkg.sv -----
// Shared types and constants of the stereo block matching disparity engine.
package bmd_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned DISP_W = 8;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned CIDX_W = 3;
  localparam int unsigned CDAT_W = 11;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_MIN_DISP = 3'd0;
  localparam logic [CIDX_W-1:0] REG_MAX_DISP = 3'd1;
  localparam logic [CIDX_W-1:0] REG_RADIUS   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_MODE     = 3'd3;
  localparam logic [CIDX_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CIDX_W-1:0] REG_HEIGHT   = 3'd5;

  // Input word kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_PAD   = 1'b1;

  // Sequencer states.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_COL   = 10'b0000000010,
    S_DSTRT = 10'b0000000100,
    S_CELL  = 10'b0000001000,
    S_RD    = 10'b0000010000,
    S_CAP   = 10'b0000100000,
    S_ACC   = 10'b0001000000,
    S_DEND  = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_SPARE = 10'b1000000000
  } bmd_state_t;

endpackage

// ----- rtl/bmd_ifs.sv -----
// Valid/ready channel interfaces of the disparity engine.
interface bmd_in_if;
  import bmd_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [PIX_W-1:0] left_pixel;
  logic [PIX_W-1:0] right_pixel;
  modport source(output valid, kind, left_pixel, right_pixel, input ready);
  modport sink(input valid, kind, left_pixel, right_pixel, output ready);
endinterface

interface bmd_out_if;
  import bmd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DISP_W-1:0] disparity;
  logic [POS_W-1:0]  out_row;
  logic [POS_W-1:0]  out_col;
  logic              last_of_run;
  modport source(output valid, disparity, out_row, out_col, last_of_run, input ready);
  modport sink(input valid, disparity, out_row, out_col, last_of_run, output ready);
endinterface

interface bmd_cfg_if;
  import bmd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/block_matching_disparity.sv -----
// Stereo block matching engine: line stores, cost sequencer and result register.
// An input word releases at most one result, or up to lag+1 at the row end, and
// no new input word is taken until its results are out. Each result searches n
// disparities with k = 1 read per window cell for absolute difference or 9 for
// census, through one shared cost unit and the single read port of each store.
// Reset is synchronous and covers control and config registers, not the stores.
module block_matching_disparity #(
  parameter int MAX_WIDTH       = 1024,
  parameter int MAX_HEIGHT      = 1024,
  parameter int MAX_RADIUS      = 7,
  parameter int MAX_DISPARITIES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  bmd_in_if.sink    in_ch,
  bmd_out_if.source out_ch,
  bmd_cfg_if.sink   cfg_ch
);
  import bmd_pkg::*;

  localparam int RING    = 2 * MAX_RADIUS + 3;
  localparam int DEPTH   = RING * MAX_WIDTH;
  localparam int AW      = $clog2(DEPTH);
  localparam int RW      = $clog2(RING);
  localparam int MAXDIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int XW0     = $clog2(MAXDIM) + 3;
  localparam int XW      = (XW0 > 14) ? XW0 : 14;
  localparam int WIN_MAX = 2 * MAX_RADIUS + 1;
  localparam int WW      = $clog2(WIN_MAX + 1);
  localparam int SUMW    = $clog2(WIN_MAX * WIN_MAX * 255 + 1);
  localparam int NW      = $clog2(MAX_DISPARITIES + 1);

  typedef logic signed [XW-1:0] crd_t;

  // Configuration registers.
  logic [7:0]  min_r, max_r;
  logic [2:0]  rad_r;
  logic        mode_r;
  logic [10:0] wid_r, hgt_r;

  // Line stores.
  logic [PIX_W-1:0] lmem [DEPTH];
  logic [PIX_W-1:0] rmem [DEPTH];
  logic [PIX_W-1:0] lq_r, rq_r;

  // Sequencer registers.
  bmd_state_t      st_r, st_nxt;
  crd_t            py_r, px_r, py_nxt, px_nxt;
  logic [RW-1:0]   pring_r, pring_nxt;
  crd_t            sy_r, sy_nxt;
  logic [RW-1:0]   sring_r, sring_nxt;
  crd_t            e_r, e_nxt, c_r, c_nxt, hi_r, hi_nxt;
  logic [NW-1:0]   i_r, i_nxt, bi_r, bi_nxt;
  logic            hb_r, hb_nxt;
  logic [SUMW-1:0] sum_r, sum_nxt, best_r, best_nxt;
  logic [WW-1:0]   a_r, a_nxt, b_r, b_nxt;
  logic [3:0]      k_r, k_nxt;
  logic [7:0]      disp_r, disp_nxt;
  logic [3:0]      rk_r;
  logic            rpend_r, lok_r, rok_r;
  logic [PIX_W-1:0] lv_r [9];
  logic [PIX_W-1:0] rv_r [9];

  // Effective configuration.
  crd_t cur_w, cur_h, cur_r, lag, win, dcur;
  logic [9:0] nraw;
  logic [NW-1:0] n_eff;

  always_comb begin
    if (wid_r == 11'd0) cur_w = crd_t'(1);
    else if (13'(wid_r) > 13'(MAX_WIDTH)) cur_w = crd_t'(MAX_WIDTH);
    else cur_w = crd_t'(wid_r);
    if (hgt_r == 11'd0) cur_h = crd_t'(1);
    else if (13'(hgt_r) > 13'(MAX_HEIGHT)) cur_h = crd_t'(MAX_HEIGHT);
    else cur_h = crd_t'(hgt_r);
    if (5'(rad_r) > 5'(MAX_RADIUS)) cur_r = crd_t'(MAX_RADIUS);
    else cur_r = crd_t'(rad_r);
    lag = cur_r + crd_t'(mode_r);
    win = crd_t'(2 * cur_r + 1);
    dcur = crd_t'(min_r) + crd_t'(i_r);
    nraw = (max_r >= min_r) ? (10'(max_r) - 10'(min_r) + 10'd1) : 10'd0;
    n_eff = (nraw > 10'(MAX_DISPARITIES)) ? NW'(MAX_DISPARITIES) : NW'(nraw);
  end

  // Neighbor offset of read slot k, raster order over the 3x3 patch.
  function automatic crd_t off_row(input logic [3:0] k);
    crd_t v;
    case (k)
      4'd0, 4'd1, 4'd2: v = crd_t'(-1);
      4'd3, 4'd4, 4'd5: v = '0;
      default:          v = crd_t'(1);
    endcase
    return v;
  endfunction

  function automatic crd_t off_col(input logic [3:0] k);
    crd_t v;
    case (k)
      4'd0, 4'd3, 4'd6: v = crd_t'(-1);
      4'd1, 4'd4, 4'd7: v = '0;
      default:          v = crd_t'(1);
    endcase
    return v;
  endfunction

  // Census code: bit set where a neighbor exceeds the center, MSB first.
  function automatic logic [7:0] census(input logic [PIX_W-1:0] p [9]);
    logic [7:0] code;
    code[7] = p[0] > p[4];
    code[6] = p[1] > p[4];
    code[5] = p[2] > p[4];
    code[4] = p[3] > p[4];
    code[3] = p[5] > p[4];
    code[2] = p[6] > p[4];
    code[1] = p[7] > p[4];
    code[0] = p[8] > p[4];
    return code;
  endfunction

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int q = 0; q < 8; q++) n = n + 4'(v[q]);
    return n;
  endfunction

  // Window cell under the cursor.
  crd_t row_c, j_c, lrow, lcol, rcol, delta, ringt;
  logic cell_in, lok, rok, rowok;
  logic [AW-1:0] laddr, raddr, waddr;
  logic [RW-1:0] rring;

  always_comb begin
    row_c = e_r - cur_r + crd_t'(a_r);
    j_c   = c_r - cur_r + crd_t'(b_r);
    cell_in = (row_c >= 0) && (row_c < cur_h) && (j_c >= 0) && (j_c < cur_w);
    lrow = row_c + off_row(k_r);
    lcol = j_c + off_col(k_r);
    rcol = j_c - dcur + off_col(k_r);
    rowok = (lrow >= 0) && (lrow < cur_h);
    lok = rowok && (lcol >= 0) && (lcol < cur_w);
    rok = rowok && (rcol >= 0) && (rcol < cur_w);
    // Rows read lie at most a ring's length behind the current input row.
    delta = sy_r - lrow;
    ringt = crd_t'(sring_r) - delta;
    if (ringt < 0) ringt = ringt + crd_t'(RING);
    rring = RW'(ringt);
    laddr = AW'(rring) * AW'(MAX_WIDTH) + AW'(lcol);
    raddr = AW'(rring) * AW'(MAX_WIDTH) + AW'(rcol);
  end

  // Cost term of the current cell.
  logic [7:0] lval, rval, term;
  always_comb begin
    lval = mode_r ? census(lv_r) : lv_r[4];
    rval = mode_r ? census(rv_r) : rv_r[4];
    if (j_c < dcur) term = lval;
    else if (mode_r) term = 8'(ones8(lval ^ rval));
    else term = (lval >= rval) ? (lval - rval) : (rval - lval);
  end

  // Input position handling.
  crd_t ax, ay, nx, ny;
  logic [RW-1:0] ar, nr;
  logic in_acc, cfg_acc, is_pad;

  assign in_ch.ready  = (st_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    ax = px_r;
    ay = py_r;
    ar = pring_r;
    if (px_r >= cur_w) begin
      ax = '0;
      ay = py_r + crd_t'(1);
      ar = (pring_r == RW'(RING - 1)) ? '0 : pring_r + 1'b1;
    end
    if (ay >= cur_h + lag) begin
      ay = '0;
      ar = '0;
    end
    nx = ax + crd_t'(1);
    ny = ay;
    nr = ar;
    if (nx >= cur_w) begin
      nx = '0;
      ny = ay + crd_t'(1);
      nr = (ar == RW'(RING - 1)) ? '0 : ar + 1'b1;
      if (ny >= cur_h + lag) begin
        ny = '0;
        nr = '0;
      end
    end
    is_pad = (ay < cur_h) && (in_ch.kind == KIND_PAD);
    waddr  = AW'(ar) * AW'(MAX_WIDTH) + AW'(ax);
  end

  // Sequencer next state.
  always_comb begin
    st_nxt = st_r;
    py_nxt = py_r; px_nxt = px_r; pring_nxt = pring_r;
    sy_nxt = sy_r; sring_nxt = sring_r;
    e_nxt = e_r; c_nxt = c_r; hi_nxt = hi_r;
    i_nxt = i_r; bi_nxt = bi_r; hb_nxt = hb_r;
    sum_nxt = sum_r; best_nxt = best_r;
    a_nxt = a_r; b_nxt = b_r; k_nxt = k_r;
    disp_nxt = disp_r;
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (is_pad) begin
            py_nxt = ay; px_nxt = ax; pring_nxt = ar;
          end else begin
            py_nxt = ny; px_nxt = nx; pring_nxt = nr;
            sy_nxt = ay; sring_nxt = ar;
            if ((ay >= lag) && ((ax >= lag) || (ax == cur_w - 1))) begin
              e_nxt  = ay - lag;
              c_nxt  = (ax >= lag) ? ax - lag : '0;
              hi_nxt = (ax == cur_w - 1) ? cur_w - crd_t'(1) : ax - lag;
              st_nxt = S_COL;
            end
          end
        end
      end
      S_COL: begin
        i_nxt = '0;
        hb_nxt = 1'b0;
        bi_nxt = '0;
        if (n_eff == '0) begin
          disp_nxt = min_r;
          st_nxt = S_OUT;
        end else begin
          st_nxt = S_DSTRT;
        end
      end
      S_DSTRT: begin
        if ((i_r >= n_eff) || (c_r < dcur)) begin
          disp_nxt = min_r + 8'(bi_r);
          st_nxt = S_OUT;
        end else begin
          a_nxt = '0; b_nxt = '0; sum_nxt = '0;
          st_nxt = S_CELL;
        end
      end
      S_CELL: begin
        if (cell_in) begin
          k_nxt = mode_r ? 4'd0 : 4'd4;
          st_nxt = S_RD;
        end
      end
      S_RD: begin
        if ((k_r == 4'd8) || !mode_r) st_nxt = S_CAP;
        else k_nxt = k_r + 4'd1;
      end
      S_CAP: st_nxt = S_ACC;
      S_ACC: sum_nxt = sum_r + SUMW'(term);
      S_DEND: begin
        if (!hb_r || (sum_r < best_r)) begin
          best_nxt = sum_r; bi_nxt = i_r; hb_nxt = 1'b1;
        end
        i_nxt = i_r + 1'b1;
        st_nxt = S_DSTRT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (c_r == hi_r) st_nxt = S_IDLE;
          else begin
            c_nxt = c_r + crd_t'(1);
            st_nxt = S_COL;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    // Step to the next window cell after a skip or an accumulation.
    if (((st_r == S_CELL) && !cell_in) || (st_r == S_ACC)) begin
      if (crd_t'(b_r) == win - 1) begin
        b_nxt = '0;
        if (crd_t'(a_r) == win - 1) st_nxt = S_DEND;
        else begin
          a_nxt = a_r + 1'b1;
          st_nxt = S_CELL;
        end
      end else begin
        b_nxt = b_r + 1'b1;
        st_nxt = S_CELL;
      end
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      py_r <= '0; px_r <= '0; pring_r <= '0;
      rpend_r <= 1'b0;
      min_r <= 8'd0; max_r <= 8'd63; rad_r <= 3'd1; mode_r <= 1'b0;
      wid_r <= 11'd640; hgt_r <= 11'd480;
    end else begin
      st_r <= st_nxt;
      py_r <= py_nxt; px_r <= px_nxt; pring_r <= pring_nxt;
      rpend_r <= (st_r == S_RD);
      if (cfg_acc) begin
        case (cfg_ch.index)
          REG_MIN_DISP: min_r  <= cfg_ch.data[7:0];
          REG_MAX_DISP: max_r  <= cfg_ch.data[7:0];
          REG_RADIUS:   rad_r  <= cfg_ch.data[2:0];
          REG_MODE:     mode_r <= cfg_ch.data[0];
          REG_WIDTH:    wid_r  <= cfg_ch.data;
          REG_HEIGHT:   hgt_r  <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    sy_r <= sy_nxt; sring_r <= sring_nxt;
    e_r <= e_nxt; c_r <= c_nxt; hi_r <= hi_nxt;
    i_r <= i_nxt; bi_r <= bi_nxt; hb_r <= hb_nxt;
    sum_r <= sum_nxt; best_r <= best_nxt;
    a_r <= a_nxt; b_r <= b_nxt; k_r <= k_nxt;
    disp_r <= disp_nxt;
    rk_r <= k_r;
    lok_r <= lok;
    rok_r <= rok;
    if (rpend_r) begin
      lv_r[rk_r] <= lok_r ? lq_r : '0;
      rv_r[rk_r] <= rok_r ? rq_r : '0;
    end
  end

  // Line stores: one write on image-row pixel words, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (in_acc && !is_pad && (ay < cur_h)) begin
      lmem[waddr] <= in_ch.left_pixel;
      rmem[waddr] <= in_ch.right_pixel;
    end
    lq_r <= lmem[laddr];
    rq_r <= rmem[raddr];
  end

  // Result word.
  assign out_ch.valid       = (st_r == S_OUT);
  assign out_ch.disparity   = disp_r;
  assign out_ch.out_row     = POS_W'(e_r);
  assign out_ch.out_col     = POS_W'(c_r);
  assign out_ch.last_of_run = (c_r == hi_r);

endmodule

// ----- rtl/bmd_checker.sv -----
// Port-level checks of the disparity engine, bound to the top level.
module bmd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [7:0] out_disp
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_disp))
    else $error("result word changed while stalled");

  // Input is never taken while a result is on offer.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // After an accepted word the engine is not both offering a result and ready for input.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid || !in_ready)
    else $error("engine state inconsistent after accept");

  // The last result of a run returns the engine to idle.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("engine did not return to idle after last result");

endmodule

bind block_matching_disparity bmd_checker u_bmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_of_run),
  .out_disp  (out_ch.disparity)
);

// ----- tb/block_matching_disparity_checker.sv -----
// Checker of the disparity engine: predicts every result word and compares it.
module block_matching_disparity_checker (
  input  logic clk,
  input  logic rst_n,
  bmd_in_if    in_mon,
  bmd_out_if   out_mon,
  bmd_cfg_if   cfg_mon,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bmd_pkg::*;

  localparam int RAD_LIM = 7;
  localparam int RING = 2 * RAD_LIM + 3;
  localparam int W_LIM = 1024;
  localparam int H_LIM = 1024;
  localparam int DISP_LIM = 64;

  typedef struct packed {
    logic [DISP_W-1:0] disparity;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              last;
  } disp_word_t;

  disp_word_t expected_disp[$];

  // Shadow of the line stores and of the registers.
  logic [PIX_W-1:0] left_rows[RING][W_LIM];
  logic [PIX_W-1:0] right_rows[RING][W_LIM];
  int pos_row, pos_col;
  logic [7:0]  min_d, max_d;
  logic [2:0]  radius;
  logic        census;
  logic [10:0] width, height;
  int cur_w, cur_h, cur_r;
  int err_count;

  function automatic int raw_pix(bit right, int row, int col);
    if (row < 0 || row >= cur_h || col < 0 || col >= cur_w) return 0;
    return right ? right_rows[row % RING][col] : left_rows[row % RING][col];
  endfunction

  // Raw intensity, or the 3x3 census code with the first neighbour in the MSB.
  function automatic int cost_pix(bit right, int row, int col);
    int center, code, weight;
    if (!census) return raw_pix(right, row, col);
    center = raw_pix(right, row, col);
    code = 0;
    weight = 128;
    for (int di = -1; di <= 1; di++) begin
      for (int dj = -1; dj <= 1; dj++) begin
        if (di != 0 || dj != 0) begin
          if (raw_pix(right, row + di, col + dj) > center) code |= weight;
          weight >>= 1;
        end
      end
    end
    return code;
  endfunction

  // Window cost search; the first minimum wins and the search stops at c < d.
  function automatic logic [7:0] best_disparity(int e, int c);
    int n, d, sum, best, best_i, row, j, lv, rv;
    n = (max_d >= min_d) ? int'(max_d) - int'(min_d) + 1 : 0;
    if (n > DISP_LIM) n = DISP_LIM;
    if (n == 0) return min_d;
    best = 32'h7fffffff;
    best_i = 0;
    for (int i = 0; i < n; i++) begin
      d = int'(min_d) + i;
      if (c < d) break;
      sum = 0;
      for (int a = -cur_r; a <= cur_r; a++) begin
        for (int b = -cur_r; b <= cur_r; b++) begin
          row = e + a;
          j = c + b;
          if (row >= 0 && row < cur_h && j >= 0 && j < cur_w) begin
            lv = cost_pix(1'b0, row, j);
            if (j < d) begin
              sum += lv;
            end else begin
              rv = cost_pix(1'b1, row, j - d);
              if (census) sum += $countones((lv ^ rv) & 8'hff);
              else sum += (lv >= rv) ? lv - rv : rv - lv;
            end
          end
        end
      end
      if (sum < best) begin
        best = sum;
        best_i = i;
      end
    end
    return 8'(int'(min_d) + best_i);
  endfunction

  // One accepted input word: store the pixels and queue the results it releases.
  task automatic accept_pixel_word(logic kind, logic [7:0] lp, logic [7:0] rp);
    int lag, y, x, lo, hi, e;
    disp_word_t w;
    cur_w = (width == 0) ? 1 : ((width > W_LIM) ? W_LIM : int'(width));
    cur_h = (height == 0) ? 1 : ((height > H_LIM) ? H_LIM : int'(height));
    cur_r = radius;
    lag = cur_r + int'(census);
    if (pos_col >= cur_w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= cur_h + lag) pos_row = 0;
    y = pos_row;
    x = pos_col;
    if (y < cur_h) begin
      if (kind == KIND_PAD) return;
      left_rows[y % RING][x] = lp;
      right_rows[y % RING][x] = rp;
    end
    lo = 0;
    hi = -1;
    if (y >= lag) begin
      e = y - lag;
      if (x >= lag) begin
        lo = x - lag;
        hi = lo;
      end
      if (x == cur_w - 1) begin
        lo = (x >= lag) ? x - lag : 0;
        hi = cur_w - 1;
      end
      for (int c = lo; c <= hi; c++) begin
        w.disparity = best_disparity(e, c);
        w.row = POS_W'(e);
        w.col = POS_W'(c);
        w.last = (c == hi);
        expected_disp = {expected_disp, w};
      end
    end
    pos_col++;
    if (pos_col >= cur_w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= cur_h + lag) pos_row = 0;
    end
  endtask

  task automatic compare_word();
    disp_word_t want;
    if (expected_disp.size() == 0) begin
      $display("%0t: unexpected word disparity %0d row %0d col %0d", $time,
               out_mon.disparity, out_mon.out_row, out_mon.out_col);
      err_count++;
      return;
    end
    want = expected_disp.pop_front();
    if (out_mon.disparity !== want.disparity) begin
      $display("%0t: disparity expected %0d actual %0d (row %0d col %0d)", $time,
               want.disparity, out_mon.disparity, want.row, want.col);
      err_count++;
    end
    if (out_mon.out_row !== want.row) begin
      $display("%0t: out_row expected %0d actual %0d", $time, want.row, out_mon.out_row);
      err_count++;
    end
    if (out_mon.out_col !== want.col) begin
      $display("%0t: out_col expected %0d actual %0d", $time, want.col, out_mon.out_col);
      err_count++;
    end
    if (out_mon.last_of_run !== want.last) begin
      $display("%0t: last_of_run expected %0d actual %0d", $time, want.last,
               out_mon.last_of_run);
      err_count++;
    end
  endtask

  // Watch the three channels at each edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      min_d = 0;
      max_d = 63;
      radius = 1;
      census = 0;
      width = 640;
      height = 480;
      pos_row = 0;
      pos_col = 0;
      expected_disp.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_MIN_DISP: min_d = cfg_mon.data[7:0];
          REG_MAX_DISP: max_d = cfg_mon.data[7:0];
          REG_RADIUS:   radius = cfg_mon.data[2:0];
          REG_MODE:     census = cfg_mon.data[0];
          REG_WIDTH:    width = cfg_mon.data;
          REG_HEIGHT:   height = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        accept_pixel_word(in_mon.kind, in_mon.left_pixel, in_mon.right_pixel);
      if (out_mon.valid && out_mon.ready) compare_word();
    end
    errors <= err_count;
    pending <= expected_disp.size();
  end

  initial begin
    err_count = 0;
  end

endmodule

// ----- tb/block_matching_disparity_tb.sv -----
// Top of the disparity engine testbench: clock, reset, stimulus and verdict.
module block_matching_disparity_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmd_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  int errors, pending;
  int sent_words;
  int idle_cycles = 0;
  bit hold_req;
  bit pause_mid;

  bmd_in_if  in_ch();
  bmd_out_if out_ch();
  bmd_cfg_if cfg_ch();

  block_matching_disparity u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  block_matching_disparity_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("block_matching_disparity_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: mostly short stalls, a few long ones, and a long hold-off on each request.
  initial begin
    int pick, len;
    out_ch.ready = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 0;
        repeat (2500) @(posedge clk);
        hold_req = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        out_ch.ready <= 1;
        len = $urandom_range(1, 25);
      end else if (pick < 95) begin
        out_ch.ready <= 0;
        len = $urandom_range(1, 4);
      end else begin
        out_ch.ready <= 0;
        len = $urandom_range(20, 120);
      end
      repeat (len) @(posedge clk);
    end
  end

  // Offer one input word after a random gap and wait until it is taken.
  task automatic send_word(logic kind, logic [7:0] lp, logic [7:0] rp);
    int pick, gap;
    pick = $urandom_range(0, 99);
    gap = (pick < 55) ? 0 : ((pick < 95) ? $urandom_range(1, 3) : $urandom_range(20, 90));
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.kind <= kind;
    in_ch.left_pixel <= lp;
    in_ch.right_pixel <= rp;
    do @(posedge clk); while (!in_ch.ready);
    sent_words++;
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] value);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
  endtask

  // The count of outstanding results is a registered output of the checker.
  task automatic drain_results();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Pixel pair at (x, y): extremes, a shifted texture, or plain noise.
  function automatic logic [15:0] pixel_pair(int pattern, int x, int y, int shift);
    logic [7:0] lp, rp;
    case (pattern)
      0: begin
        lp = ((x + y) % 2) ? 8'hff : 8'h00;
        rp = (y % 2) ? ~lp : lp;
      end
      1: begin
        lp = 8'((x * 37 + y * 11) ^ (x * x));
        rp = 8'(((x + shift) * 37 + y * 11) ^ ((x + shift) * (x + shift)));
        if ($urandom_range(0, 7) == 0) rp = rp ^ 8'($urandom_range(0, 15));
      end
      default: begin
        lp = 8'($urandom);
        rp = 8'($urandom);
      end
    endcase
    return {lp, rp};
  endfunction

  // One whole frame: image rows with stray padding, then the flush rows.
  task automatic run_frame(int w, int h, int lag, int pattern);
    int shift;
    logic [15:0] pair;
    shift = $urandom_range(0, 5);
    for (int y = 0; y < h + lag; y++) begin
      for (int x = 0; x < w; x++) begin
        if (pause_mid && y == h / 2 && x == 0) begin
          drain_results();
          pause_mid = 0;
        end
        pair = pixel_pair(pattern, x, y, shift);
        if (y < h) begin
          if ($urandom_range(0, 11) == 0) send_word(KIND_PAD, 8'($urandom), 8'($urandom));
          send_word(KIND_PIXEL, pair[15:8], pair[7:0]);
        end else begin
          send_word($urandom_range(0, 1) ? KIND_PAD : KIND_PIXEL, pair[15:8], pair[7:0]);
        end
      end
    end
  endtask

  // New settings once the engine has gone quiet, then a number of frames.
  task automatic run_phase(int dmin, int dmax, int r, int mode, int w, int h,
                           int pattern, int frames);
    int w_eff, h_eff;
    drain_results();
    repeat (300) @(posedge clk);
    write_reg(REG_MIN_DISP, CDAT_W'(dmin));
    write_reg(REG_MAX_DISP, CDAT_W'(dmax));
    write_reg(REG_RADIUS, CDAT_W'(r));
    write_reg(REG_MODE, CDAT_W'(mode));
    write_reg(REG_WIDTH, CDAT_W'(w));
    write_reg(REG_HEIGHT, CDAT_W'(h));
    w_eff = (w == 0) ? 1 : ((w > 1024) ? 1024 : w);
    h_eff = (h == 0) ? 1 : ((h > 1024) ? 1024 : h);
    for (int f = 0; f < frames; f++) run_frame(w_eff, h_eff, r + mode, pattern);
  endtask

  initial begin
    int dmin;
    rst_n = 0;
    sent_words = 0;
    hold_req = 0;
    pause_mid = 0;
    in_ch.valid = 0;
    in_ch.kind = KIND_PIXEL;
    in_ch.left_pixel = 0;
    in_ch.right_pixel = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = REG_MIN_DISP;
    cfg_ch.data = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed settings: extreme pixels, census, clipped range, empty range,
    // largest window, degenerate image sizes.
    hold_req = 1;
    run_phase(0, 3, 1, 0, 6, 4, 0, 1);
    pause_mid = 1;
    run_phase(2, 5, 1, 1, 6, 4, 1, 1);
    hold_req = 1;
    run_phase(0, 255, 0, 0, 70, 1, 1, 1);
    run_phase(5, 2, 2, 0, 5, 3, 2, 1);
    run_phase(0, 1, 7, 1, 4, 3, 0, 1);
    run_phase(255, 255, 0, 0, 0, 0, 2, 2);
    run_phase(0, 0, 0, 1, 5, 1, 2, 1);
    run_phase(0, 0, 0, 0, 1, 9, 2, 1);

    // Random settings with small images and small searches.
    while (sent_words < 250) begin
      dmin = ($urandom_range(0, 9) == 0) ? $urandom_range(240, 255) : $urandom_range(0, 6);
      run_phase(dmin, ($urandom_range(0, 9) == 0) ? 255 : dmin + $urandom_range(0, 5),
                $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(1, 8),
                $urandom_range(1, 6), 2, 1);
    end

    drain_results();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("block_matching_disparity_tb: clean");
    end else begin
      $display("block_matching_disparity_tb: errors");
    end
    $finish;
  end

endmodule
